### src/gn3d_pkg.sv
// shared constants and gradient helper for the 3d gradient noise block
`timescale 1ns / 1ps
package gn3d_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 24;
    localparam int IDX_W      = 8;
    localparam int TABLE_SIZE = 1 << IDX_W;
    localparam int OP_W       = 24;
    localparam int GRAD_W     = 20;
    localparam int FADE_W     = 18;
    localparam int OUT_W      = 17;

    localparam logic signed [OP_W-1:0] ONE_Q     = OP_W'(1) <<< FRAC_BITS;
    localparam logic signed [OP_W-1:0] FIFTEEN_Q = OP_W'(15) <<< FRAC_BITS;
    localparam logic signed [OP_W-1:0] TEN_Q     = OP_W'(10) <<< FRAC_BITS;
    localparam logic [OUT_W-1:0]       OUT_MAX   = OUT_W'(1) << FRAC_BITS;

    typedef logic signed [FRAC_BITS+1:0] crd_t;
    typedef logic signed [GRAD_W-1:0]    grad_t;

    // dot product of corner offset with one of 12 gradient directions
    function automatic grad_t corner_grad(input logic [3:0] h, input crd_t x,
                                          input crd_t y, input crd_t z);
        crd_t  u;
        crd_t  v;
        grad_t su;
        grad_t sv;
        u = (h < 4'd8) ? x : y;
        if (h < 4'd4) begin
            v = y;
        end else if (h == 4'd12 || h == 4'd14) begin
            v = x;
        end else begin
            v = z;
        end
        su = GRAD_W'(u);
        sv = GRAD_W'(v);
        if (h[0]) su = -su;
        if (h[1]) sv = -sv;
        return su + sv;
    endfunction

endpackage

### src/gradient_noise_3d.sv
// 3d gradient noise evaluator with loadable permutation table
//
// channel  dir  ports
// s_       in   s_valid s_ready s_req_type s_coord_x s_coord_y s_coord_z
//                s_entry_index s_entry_value
// m_       out  m_valid m_ready m_noise_value
//
// a load item writes the table when it is accepted; an evaluate item runs
// through the table lookup, fade, blend and output states, and no new item
// is accepted until it is done, as the table has a single read port and
// there is one shared multiplier
// after reset the table is set to the identity before any item is taken
// a result waiting on m_ready holds the next in S_OUT, which takes no items
`timescale 1ns / 1ps
module gradient_noise_3d
    import gn3d_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [COORD_W-1:0]   s_coord_x,
    input  logic [COORD_W-1:0]   s_coord_y,
    input  logic [COORD_W-1:0]   s_coord_z,
    input  logic [IDX_W-1:0]     s_entry_index,
    input  logic [IDX_W-1:0]     s_entry_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_noise_value
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_FADE, S_BLEND, S_OUT
    } state_t;

    state_t                  state_reg;
    logic [3:0]              cnt_reg;
    logic [1:0]              sel_reg;
    logic [2:0]              bi_reg;
    logic [3:0]              count_reg;
    logic [IDX_W-1:0]        clr_reg;
    logic [IDX_W-1:0]        ix_reg, iy_reg, iz_reg;
    logic [FRAC_BITS-1:0]    fx_reg, fy_reg, fz_reg;
    logic [IDX_W-1:0]        a_reg, b_reg, aa_reg, ab_reg, ba_reg, bb_reg;
    grad_t                   g_reg [8];
    logic signed [FADE_W-1:0] fade_reg [3];
    logic signed [OP_W-1:0]  opa_reg, opb_reg, prod_reg, s_tmp_reg;
    logic                    m_valid_reg;
    logic [OUT_W-1:0]        m_noise_reg;

    logic [IDX_W-1:0]        mem [TABLE_SIZE];
    logic [IDX_W-1:0]        rdata_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr, wr_data;

    logic                    accept;
    logic                    out_free;

    // shared multiplier, sign-magnitude with round half away from zero
    logic [OP_W-1:0]         ma, mb;
    logic [2*OP_W-1:0]       mround;
    logic [OP_W-1:0]         mmag;
    logic                    mneg;
    logic signed [OP_W-1:0]  mul_q;

    logic [3:0]              kk;
    crd_t                    cx, cy, cz;
    logic [FRAC_BITS-1:0]    tsel;
    logic signed [OP_W-1:0]  tq;
    logic signed [FADE_W-1:0] wsel;
    logic signed [OP_W-1:0]  bsum;
    logic signed [GRAD_W:0]  rsum;
    logic [GRAD_W:0]         rhalf;
    logic [OUT_W-1:0]        out_val;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_noise_value = m_noise_reg;

    always_comb begin
        ma     = opa_reg[OP_W-1] ? OP_W'(-opa_reg) : OP_W'(opa_reg);
        mb     = opb_reg[OP_W-1] ? OP_W'(-opb_reg) : OP_W'(opb_reg);
        mneg   = opa_reg[OP_W-1] ^ opb_reg[OP_W-1];
        mround = ma * mb + ((2*OP_W)'(1) << (FRAC_BITS - 1));
        mmag   = mround[FRAC_BITS +: OP_W];
        mul_q  = mneg ? -$signed(mmag) : $signed(mmag);
    end

    always_comb begin
        kk = cnt_reg - 4'd7;
        cx = kk[0] ? crd_t'({2'b00, fx_reg}) - crd_t'(ONE_Q)
                   : crd_t'({2'b00, fx_reg});
        cy = kk[1] ? crd_t'({2'b00, fy_reg}) - crd_t'(ONE_Q)
                   : crd_t'({2'b00, fy_reg});
        cz = kk[2] ? crd_t'({2'b00, fz_reg}) - crd_t'(ONE_Q)
                   : crd_t'({2'b00, fz_reg});
        case (sel_reg)
            2'd0:    tsel = fx_reg;
            2'd1:    tsel = fy_reg;
            default: tsel = fz_reg;
        endcase
        tq = OP_W'({1'b0, tsel});
        if (bi_reg < 3'd4) begin
            wsel = fade_reg[0];
        end else if (bi_reg < 3'd6) begin
            wsel = fade_reg[1];
        end else begin
            wsel = fade_reg[2];
        end
        bsum  = OP_W'(g_reg[0]) + prod_reg;
        rsum  = (GRAD_W+1)'(g_reg[0]) + (GRAD_W+1)'(ONE_Q);
        rhalf = (GRAD_W+1)'(rsum + (GRAD_W+1)'(1)) >> 1;
        if (rsum <= 0) begin
            out_val = '0;
        end else if (rhalf > (GRAD_W+1)'(OUT_MAX)) begin
            out_val = OUT_MAX;
        end else begin
            out_val = rhalf[OUT_W-1:0];
        end
    end

    always_comb begin
        case (cnt_reg)
            4'd0:    rd_addr = ix_reg;
            4'd1:    rd_addr = ix_reg + 1'b1;
            4'd2:    rd_addr = a_reg;
            4'd3:    rd_addr = a_reg + 1'b1;
            4'd4:    rd_addr = b_reg;
            4'd5:    rd_addr = b_reg + 1'b1;
            4'd6:    rd_addr = aa_reg;
            4'd7:    rd_addr = ba_reg;
            4'd8:    rd_addr = ab_reg;
            4'd9:    rd_addr = bb_reg;
            4'd10:   rd_addr = aa_reg + 1'b1;
            4'd11:   rd_addr = ba_reg + 1'b1;
            4'd12:   rd_addr = ab_reg + 1'b1;
            4'd13:   rd_addr = bb_reg + 1'b1;
            default: rd_addr = ix_reg;
        endcase
        wr_en   = (state_reg == S_CLEAR) || (accept && s_req_type);
        wr_addr = (state_reg == S_CLEAR) ? clr_reg : s_entry_index;
        wr_data = (state_reg == S_CLEAR) ? clr_reg : s_entry_value;
    end

    // permutation table
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            cnt_reg     <= '0;
            sel_reg     <= '0;
            bi_reg      <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            prod_reg <= mul_q;
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IDX_W'(TABLE_SIZE - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && !s_req_type) begin
                        ix_reg    <= s_coord_x[FRAC_BITS +: IDX_W];
                        iy_reg    <= s_coord_y[FRAC_BITS +: IDX_W];
                        iz_reg    <= s_coord_z[FRAC_BITS +: IDX_W];
                        fx_reg    <= s_coord_x[FRAC_BITS-1:0];
                        fy_reg    <= s_coord_y[FRAC_BITS-1:0];
                        fz_reg    <= s_coord_z[FRAC_BITS-1:0];
                        cnt_reg   <= '0;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    case (cnt_reg)
                        4'd1:    a_reg  <= rdata_reg + iy_reg;
                        4'd2:    b_reg  <= rdata_reg + iy_reg;
                        4'd3:    aa_reg <= rdata_reg + iz_reg;
                        4'd4:    ab_reg <= rdata_reg + iz_reg;
                        4'd5:    ba_reg <= rdata_reg + iz_reg;
                        4'd6:    bb_reg <= rdata_reg + iz_reg;
                        default: begin
                            if (cnt_reg >= 4'd7) begin
                                g_reg[kk[2:0]] <= corner_grad(rdata_reg[3:0], cx, cy, cz);
                            end
                        end
                    endcase
                    if (cnt_reg == 4'd14) begin
                        cnt_reg   <= '0;
                        sel_reg   <= '0;
                        state_reg <= S_FADE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_FADE: begin
                    case (cnt_reg)
                        4'd0: begin
                            opa_reg <= tq;
                            opb_reg <= OP_W'(tq * 6) - FIFTEEN_Q;
                        end
                        4'd1: begin
                            opa_reg <= tq;
                            opb_reg <= tq;
                        end
                        4'd2:    s_tmp_reg <= prod_reg + TEN_Q;
                        4'd3: begin
                            opa_reg <= prod_reg;
                            opb_reg <= tq;
                        end
                        4'd5: begin
                            opa_reg <= prod_reg;
                            opb_reg <= s_tmp_reg;
                        end
                        4'd7:    fade_reg[sel_reg] <= prod_reg[FADE_W-1:0];
                        default: ;
                    endcase
                    if (cnt_reg == 4'd7) begin
                        cnt_reg <= '0;
                        if (sel_reg == 2'd2) begin
                            bi_reg    <= '0;
                            count_reg <= 4'd8;
                            state_reg <= S_BLEND;
                        end else begin
                            sel_reg <= sel_reg + 1'b1;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_BLEND: begin
                    case (cnt_reg)
                        4'd0: begin
                            opa_reg <= OP_W'(wsel);
                            opb_reg <= OP_W'(g_reg[1]) - OP_W'(g_reg[0]);
                        end
                        4'd2: begin
                            // pop the pair, push the blended value at the tail
                            for (int i = 0; i < 8; i++) begin
                                if (4'(i) == count_reg - 4'd2) begin
                                    g_reg[i] <= bsum[GRAD_W-1:0];
                                end else if (i < 6) begin
                                    g_reg[i] <= g_reg[(i + 2) & 7];
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (cnt_reg == 4'd2) begin
                        cnt_reg   <= '0;
                        count_reg <= count_reg - 1'b1;
                        bi_reg    <= bi_reg + 1'b1;
                        if (bi_reg == 3'd6) begin
                            state_reg <= S_OUT;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_noise_reg <= out_val;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
